// ===== sv/pdq_pkg.sv =====
// Shared types and constants for the positional deque.
// Used by pdq_cell and positional_deque; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pdq_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the request and response fields.
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 5;
  localparam int DATA_IO_W = 32;
  localparam int OCC_W     = 5;
  localparam int STATUS_W  = 2;

  // Index width for cell control; covers every supported depth plus one.
  localparam int IDX_W = 9;

  // Request functions.
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_TAIL = 3'd0,
    FN_POP_HEAD  = 3'd1,
    FN_PUSH_HEAD = 3'd2,
    FN_POP_TAIL  = 3'd3,
    FN_READ      = 3'd4,
    FN_REMOVE    = 3'd5,
    FN_INSERT    = 3'd6,
    FN_NOP       = 3'd7
  } func_e;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_FILL  = 2'd3
  } cell_cmd_e;

  // Broadcast control from the sequencer to the row of cells.
  typedef struct packed {
    cell_cmd_e        cmd;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pdq_cell.sv =====
// One storage cell of the positional deque row.
// Depends on pdq_pkg for the broadcast control type.
`timescale 1ns / 1ps
`default_nettype none

module pdq_cell #(
  parameter int DATA_WIDTH = pdq_pkg::DATA_WIDTH_DEF,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                  clk_i,
  input  wire pdq_pkg::cell_ctl_t    ctl_i,
  input  wire logic [DATA_WIDTH-1:0] val_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output logic      [DATA_WIDTH-1:0] q_o,
  output logic      [DATA_WIDTH-1:0] rd_o
);
  import pdq_pkg::*;

  localparam logic [IDX_W-1:0] MyIdx   = IDX_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] NextIdx = IDX_W'(CELL_IDX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // Each cell compares its own index against the broadcast window.
  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CMD_OPEN: begin
        // Entries from the gap to the old tail move one place back.
        if (MyIdx == ctl_i.lo) begin
          data_d = val_i;
        end else if (MyIdx > ctl_i.lo && MyIdx <= ctl_i.hi) begin
          data_d = left_i;
        end
      end
      CMD_CLOSE: begin
        // Entries behind the removed one move one place forward.
        if (MyIdx >= ctl_i.lo && NextIdx < ctl_i.hi) begin
          data_d = right_i;
        end
      end
      CMD_FILL: begin
        // Padding past the old tail up to the insert position.
        if (MyIdx >= ctl_i.lo && MyIdx < ctl_i.hi) begin
          data_d = val_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o  = data_q;
  assign rd_o = (ctl_i.rd_en && MyIdx == ctl_i.rd_idx) ? data_q : '0;

endmodule

`default_nettype wire

// ===== sv/positional_deque.sv =====
// Top level of the positional deque: request decode, entry count and the row of cells.
// Depends on pdq_pkg and pdq_cell.
//
//   Channel   Handshake           Payload
//   request   start_i / busy_o    func_i, position_i, data_in_i
//   response  valid_o (strobe)    data_out_o, occupancy_o, status_o
//
// busy_o stays low, so a request can be accepted at every clock edge.
// The response appears on the cycle after acceptance and lasts one cycle.
// Shifts, padding and reads all happen together: every cell compares
// its index with the broadcast window and loads from a neighbor or the input.
// Reset clears the entry count; entry contents are undefined until written.
// The receiver cannot stall the response.
`timescale 1ns / 1ps
`default_nettype none

module positional_deque #(
  parameter int DEPTH      = pdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [pdq_pkg::FUNC_W-1:0]       func_i,
  input  wire logic [pdq_pkg::POS_W-1:0]        position_i,
  input  wire logic [pdq_pkg::DATA_IO_W-1:0]    data_in_i,
  output logic                                  valid_o,
  output logic      [pdq_pkg::DATA_IO_W-1:0]    data_out_o,
  output logic      [pdq_pkg::OCC_W-1:0]        occupancy_o,
  output logic      [pdq_pkg::STATUS_W-1:0]     status_o
);
  import pdq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int XW    = (DATA_WIDTH > DATA_IO_W) ? DATA_WIDTH : DATA_IO_W;
  localparam logic [IDX_W-1:0] DepthIdx = IDX_W'(DEPTH);

  logic                   accept;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       n_ext, p_ext, new_cnt;
  func_e                  func;
  status_e                st;
  cell_ctl_t              ctl;
  logic [XW-1:0]          din_x, dout_x;
  logic [DATA_WIDTH-1:0]  val;
  logic [DATA_WIDTH-1:0]  cell_q  [DEPTH];
  logic [DATA_WIDTH-1:0]  cell_rd [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_or;

  logic                   valid_q;
  logic [DATA_IO_W-1:0]   dout_q;
  logic [OCC_W-1:0]       occ_q;
  status_e                status_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign func  = func_e'(func_i);
  assign n_ext = IDX_W'(count_q);
  assign p_ext = IDX_W'(position_i);
  assign din_x = XW'(data_in_i);
  assign val   = din_x[DATA_WIDTH-1:0];

  // Request decode: status, new count and the window broadcast to the cells.
  always_comb begin
    st         = ST_OK;
    new_cnt    = n_ext;
    ctl.cmd    = CMD_HOLD;
    ctl.lo     = '0;
    ctl.hi     = n_ext;
    ctl.rd_idx = '0;
    ctl.rd_en  = 1'b0;
    case (func)
      FN_PUSH_TAIL, FN_PUSH_HEAD: begin
        if (n_ext >= DepthIdx) begin
          st = ST_FULL;
        end else begin
          ctl.cmd = CMD_OPEN;
          ctl.lo  = (func == FN_PUSH_TAIL) ? n_ext : '0;
          new_cnt = n_ext + 1'b1;
        end
      end
      FN_POP_HEAD: begin
        if (n_ext == '0) begin
          st = ST_EMPTY;
        end else begin
          ctl.cmd   = CMD_CLOSE;
          ctl.rd_en = 1'b1;
          new_cnt   = n_ext - 1'b1;
        end
      end
      FN_POP_TAIL: begin
        if (n_ext == '0) begin
          st = ST_EMPTY;
        end else begin
          ctl.rd_idx = n_ext - 1'b1;
          ctl.rd_en  = 1'b1;
          new_cnt    = n_ext - 1'b1;
        end
      end
      FN_READ, FN_REMOVE: begin
        if (n_ext == '0) begin
          st = ST_EMPTY;
        end else if (p_ext == '0 || p_ext > n_ext) begin
          st = ST_BADPOS;
        end else begin
          ctl.rd_idx = p_ext - 1'b1;
          ctl.rd_en  = 1'b1;
          if (func == FN_REMOVE) begin
            ctl.cmd = CMD_CLOSE;
            ctl.lo  = p_ext - 1'b1;
            new_cnt = n_ext - 1'b1;
          end
        end
      end
      FN_INSERT: begin
        if (p_ext == '0 || p_ext > DepthIdx) begin
          st = ST_BADPOS;
        end else if (p_ext > n_ext) begin
          ctl.cmd = CMD_FILL;
          ctl.lo  = n_ext;
          ctl.hi  = p_ext;
          new_cnt = p_ext;
        end else if (n_ext >= DepthIdx) begin
          st = ST_FULL;
        end else begin
          ctl.cmd = CMD_OPEN;
          ctl.lo  = p_ext - 1'b1;
          new_cnt = n_ext + 1'b1;
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
    // Without an accepted beat the row holds still.
    if (!accept) begin
      ctl.cmd   = CMD_HOLD;
      ctl.rd_en = 1'b0;
    end
  end

  assign count_d = accept ? new_cnt[CNT_W-1:0] : count_q;

  // Row of cells, each linked to its two neighbors.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_q[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_q[k+1];
    end
    pdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CELL_IDX   (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .val_i   (val),
      .left_i  (left),
      .right_i (right),
      .q_o     (cell_q[k]),
      .rd_o    (cell_rd[k])
    );
  end

  // Only the selected cell drives a nonzero read value.
  always_comb begin
    rd_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_or = rd_or | cell_rd[k];
    end
  end

  assign dout_x = XW'(rd_or);

  // Control state: entry count and response strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      valid_q <= accept;
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dout_q   <= dout_x[DATA_IO_W-1:0];
      occ_q    <= OCC_W'(new_cnt);
      status_q <= st;
    end
  end

  assign valid_o     = valid_q;
  assign data_out_o  = dout_q;
  assign occupancy_o = occ_q;
  assign status_o    = status_q;

  // Every accepted beat gives exactly one response on the next cycle.
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o)
    else $error("accepted request gave no response");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !valid_o)
    else $error("response without a request");

  // The reported occupancy matches the internal count.
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> occupancy_o == OCC_W'(count_q))
    else $error("occupancy disagrees with entry count");

  // An underflow can only be reported on an empty deque, with zero read data.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_EMPTY) |-> (count_q == '0 && data_out_o == '0))
    else $error("underflow reported with entries held");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    IDX_W'(count_q) <= DepthIdx)
    else $error("entry count exceeds depth");

endmodule

`default_nettype wire
